FILE: rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, constants and helpers of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

   // Table size default and allocation granule (a power of two)
   localparam int FREE_SEGMENTS_DEF = 64;
   localparam int GRANULE_BYTES     = 32;

   // Register reset values and the length ceiling
   localparam logic [31:0] POOL_START_RST  = 32'h8000_0000;
   localparam logic [30:0] POOL_LENGTH_RST = 31'h4000_0000;
   localparam logic [30:0] LENGTH_MAX      = 31'h7FFF_FFFF;

   // Configuration register indexes
   localparam logic CSR_POOL_START  = 1'b0;
   localparam logic CSR_POOL_LENGTH = 1'b1;

   // Request kinds
   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // One free segment as stored in the table
   typedef struct packed {
      logic [31:0] start;
      logic [30:0] length;
   } seg_type;

   // Pool configuration handed to the engine
   typedef struct packed {
      logic [31:0] start;
      logic [30:0] length;
      logic        reload;
   } pool_cfg_type;

   // Saturate a merged length at the largest representable length
   function automatic logic [30:0] cap_len(input logic [33:0] v);
      logic [30:0] r;
      r = (v > {3'b000, LENGTH_MAX}) ? LENGTH_MAX : v[30:0];
      return r;
   endfunction

endpackage

FILE: rtl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ffra_engine.sv
// ----------------------------------------------------------------------------
// ffra_engine
// Sequencer that scans, splits, merges and shifts the free-segment table.
// ----------------------------------------------------------------------------
module ffra_engine #(
   parameter int FREE_SEGMENTS = ffra_pkg::FREE_SEGMENTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ffra_pkg::pool_cfg_type       cfg,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [31:0]                  req_extent,
   input  logic [31:0]                  req_range_base,
   output logic                         rsp_valid,
   output logic [31:0]                  rsp_address,
   output logic [1:0]                   rsp_status,
   output logic                         ram_wr_en,
   output logic [$clog2(FREE_SEGMENTS)-1:0] ram_wr_addr,
   output ffra_pkg::seg_type            ram_wr_data,
   output logic [$clog2(FREE_SEGMENTS)-1:0] ram_rd_addr,
   input  ffra_pkg::seg_type            ram_rd_data
);
   import ffra_pkg::*;

   localparam int IW = $clog2(FREE_SEGMENTS);
   localparam int CW = $clog2(FREE_SEGMENTS + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(FREE_SEGMENTS);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_EVAL    = 4'd3;
   localparam logic [3:0] S_RESOLVE = 4'd4;
   localparam logic [3:0] S_SHD_RD  = 4'd5;
   localparam logic [3:0] S_SHD_WR  = 4'd6;
   localparam logic [3:0] S_SHU_RD  = 4'd7;
   localparam logic [3:0] S_SHU_WR  = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          kind_ff, kind_in;
   logic [31:0]   size_ff, size_in;
   logic [31:0]   base_ff, base_in;
   logic [31:0]   addr_ff, addr_in;
   seg_type       prev_ff, prev_in;
   logic          prev_valid_ff, prev_valid_in;
   seg_type       cur_ff, cur_in;
   logic          cur_valid_ff, cur_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_address_ff, rsp_address_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          range_bad;
   logic [32:0]   round_sum;
   logic [31:0]   req_size;
   logic [31:0]   end_addr;
   logic          merge_prev;
   logic          merge_next;
   logic [33:0]   sum_prev;
   logic [33:0]   sum_both;
   logic [33:0]   sum_next;
   logic [CW-1:0] ptr_m1;
   logic [CW-1:0] idx_p1;
   logic [CW-1:0] idx_m1;

   // Extent check and round-up to the granule
   assign range_bad = (req_extent == 32'd0) || (req_extent > {1'b0, cfg.length});
   assign round_sum = {1'b0, req_extent} + 33'(GRANULE_BYTES - 1);
   assign req_size  = round_sum[31:0] & ~32'(GRANULE_BYTES - 1);

   // Neighbor merge decisions for a release
   assign end_addr   = base_ff + size_ff;
   assign merge_prev = prev_valid_ff && ((prev_ff.start + {1'b0, prev_ff.length}) == base_ff);
   assign merge_next = cur_valid_ff && (cur_ff.start == end_addr);
   assign sum_prev   = {3'b000, prev_ff.length} + {2'b00, size_ff};
   assign sum_both   = sum_prev + {3'b000, cur_ff.length};
   assign sum_next   = {3'b000, cur_ff.length} + {2'b00, size_ff};
   assign ptr_m1     = ptr_ff - CNT_ONE;
   assign idx_p1     = idx_ff + CNT_ONE;
   assign idx_m1     = idx_ff - CNT_ONE;

   // Sequence one transaction over the table
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      idx_in          = idx_ff;
      kind_in         = kind_ff;
      size_in         = size_ff;
      base_in         = base_ff;
      addr_in         = addr_ff;
      prev_in         = prev_ff;
      prev_valid_in   = prev_valid_ff;
      cur_in          = cur_ff;
      cur_valid_in    = cur_valid_ff;
      rsp_valid_in    = 1'b0;
      rsp_address_in  = rsp_address_ff;
      rsp_status_in   = rsp_status_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = '0;
      ram_wr_data     = '0;
      ram_rd_addr     = '0;
      case (state_ff)
         S_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '{start: cfg.start, length: cfg.length};
            count_in    = (cfg.length != 31'd0) ? CNT_ONE : '0;
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            if (cfg.reload) begin
               // Reload the table as one segment over the new pool
               ram_wr_en   = 1'b1;
               ram_wr_data = '{start: cfg.start, length: cfg.length};
               count_in    = (cfg.length != 31'd0) ? CNT_ONE : '0;
            end else if (start) begin
               kind_in       = req_kind;
               size_in       = req_size;
               base_in       = req_range_base;
               addr_in       = '0;
               ptr_in        = '0;
               prev_valid_in = 1'b0;
               if (range_bad) begin
                  rsp_valid_in   = 1'b1;
                  rsp_address_in = '0;
                  rsp_status_in  = ST_RANGE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ptr_ff == count_ff) begin
               if (kind_ff == KIND_ALLOC) begin
                  rsp_valid_in   = 1'b1;
                  rsp_address_in = '0;
                  rsp_status_in  = ST_EXHAUSTED;
                  state_in       = S_IDLE;
               end else begin
                  cur_valid_in = 1'b0;
                  state_in     = S_RESOLVE;
               end
            end else begin
               ram_rd_addr = ptr_ff[IW-1:0];
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (kind_ff == KIND_ALLOC) begin
               if ({1'b0, ram_rd_data.length} >= size_ff) begin
                  addr_in = ram_rd_data.start;
                  if ({1'b0, ram_rd_data.length} == size_ff) begin
                     idx_in   = ptr_ff;
                     state_in = S_SHD_RD;
                  end else begin
                     // Shrink the segment from its low end
                     ram_wr_en          = 1'b1;
                     ram_wr_addr        = ptr_ff[IW-1:0];
                     ram_wr_data.start  = ram_rd_data.start + size_ff;
                     ram_wr_data.length = ram_rd_data.length - size_ff[30:0];
                     rsp_valid_in       = 1'b1;
                     rsp_address_in     = ram_rd_data.start;
                     rsp_status_in      = ST_OK;
                     state_in           = S_IDLE;
                  end
               end else begin
                  ptr_in   = ptr_ff + CNT_ONE;
                  state_in = S_SCAN;
               end
            end else begin
               if (ram_rd_data.start < base_ff) begin
                  prev_in       = ram_rd_data;
                  prev_valid_in = 1'b1;
                  ptr_in        = ptr_ff + CNT_ONE;
                  state_in      = S_SCAN;
               end else begin
                  cur_in       = ram_rd_data;
                  cur_valid_in = 1'b1;
                  state_in     = S_RESOLVE;
               end
            end
         end
         S_RESOLVE: begin
            rsp_address_in = '0;
            rsp_status_in  = ST_OK;
            if (merge_prev && merge_next) begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = ptr_m1[IW-1:0];
               ram_wr_data.start  = prev_ff.start;
               ram_wr_data.length = cap_len(sum_both);
               idx_in             = ptr_ff;
               state_in           = S_SHD_RD;
            end else if (merge_prev) begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = ptr_m1[IW-1:0];
               ram_wr_data.start  = prev_ff.start;
               ram_wr_data.length = cap_len(sum_prev);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else if (merge_next) begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = ptr_ff[IW-1:0];
               ram_wr_data.start  = base_ff;
               ram_wr_data.length = cap_len(sum_next);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else if (cur_valid_ff && (cur_ff.start == base_ff)) begin
               // Base already starts a free segment: leave the table alone
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (count_ff >= CNT_FULL) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end else begin
               idx_in   = count_ff;
               state_in = S_SHU_RD;
            end
         end
         S_SHD_RD: begin
            // Close the gap: move entries above idx down by one
            if (idx_p1 < count_ff) begin
               ram_rd_addr = idx_p1[IW-1:0];
               state_in    = S_SHD_WR;
            end else begin
               count_in       = count_ff - CNT_ONE;
               rsp_valid_in   = 1'b1;
               rsp_address_in = addr_ff;
               rsp_status_in  = ST_OK;
               state_in       = S_IDLE;
            end
         end
         S_SHD_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff[IW-1:0];
            ram_wr_data = ram_rd_data;
            idx_in      = idx_p1;
            state_in    = S_SHD_RD;
         end
         S_SHU_RD: begin
            // Open a slot at ptr: move entries up by one, top first
            if (idx_ff > ptr_ff) begin
               ram_rd_addr = idx_m1[IW-1:0];
               state_in    = S_SHU_WR;
            end else begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = ptr_ff[IW-1:0];
               ram_wr_data.start  = base_ff;
               ram_wr_data.length = cap_len({2'b00, size_ff});
               count_in           = count_ff + CNT_ONE;
               rsp_valid_in       = 1'b1;
               rsp_address_in     = '0;
               rsp_status_in      = ST_OK;
               state_in           = S_IDLE;
            end
         end
         S_SHU_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff[IW-1:0];
            ram_wr_data = ram_rd_data;
            idx_in      = idx_m1;
            state_in    = S_SHU_RD;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         prev_valid_ff <= 1'b0;
         cur_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_valid_ff <= prev_valid_in;
         cur_valid_ff  <= cur_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      idx_ff         <= idx_in;
      kind_ff        <= kind_in;
      size_ff        <= size_in;
      base_ff        <= base_in;
      addr_ff        <= addr_in;
      prev_ff        <= prev_in;
      cur_ff         <= cur_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign busy        = (state_ff != S_IDLE) || cfg.reload;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

FILE: rtl/first_fit_range_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top
// Allocates and releases address ranges from a pool kept as a sorted,
// coalescing table of free segments held in a single RAM.
// ----------------------------------------------------------------------------
// Timing: a refused extent is answered from idle without a table scan; other
//   transactions take time for each table entry scanned and each entry shifted
//   plus the resolve step, set by the single read port and single write port
//   of the table RAM. One transaction is in work at a time.
//   Results cannot be stalled.
// Reset: synchronous; the first cycle after reset loads the whole pool as one
//   segment (busy high). A register write made while idle reloads the table.
module first_fit_range_allocator_top #(
   parameter int FREE_SEGMENTS = ffra_pkg::FREE_SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_extent,
   input  logic [31:0] req_range_base,
   output logic        rsp_valid,
   output logic [31:0] rsp_address,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import ffra_pkg::*;

   localparam int IW = $clog2(FREE_SEGMENTS);

   logic [31:0]   pool_start_ff, pool_start_in;
   logic [30:0]   pool_length_ff, pool_length_in;
   logic          reload_ff, reload_in;
   pool_cfg_type  cfg;
   logic          ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   seg_type       ram_wr_data;
   logic [IW-1:0] ram_rd_addr;
   seg_type       ram_rd_data;

   // Decode register writes
   always_comb begin
      pool_start_in  = pool_start_ff;
      pool_length_in = pool_length_ff;
      reload_in      = csr_we;
      if (csr_we) begin
         case (csr_index)
            CSR_POOL_START:  pool_start_in  = csr_wdata;
            CSR_POOL_LENGTH: pool_length_in = csr_wdata[30:0];
            default:         pool_start_in  = pool_start_ff;
         endcase
      end
   end

   // Hold pool registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_start_ff  <= POOL_START_RST;
         pool_length_ff <= POOL_LENGTH_RST;
         reload_ff      <= 1'b0;
      end else begin
         pool_start_ff  <= pool_start_in;
         pool_length_ff <= pool_length_in;
         reload_ff      <= reload_in;
      end
   end

   assign cfg = '{start: pool_start_ff, length: pool_length_ff, reload: reload_ff};

   ffra_engine #(
      .FREE_SEGMENTS (FREE_SEGMENTS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_extent     (req_extent),
      .req_range_base (req_range_base),
      .rsp_valid      (rsp_valid),
      .rsp_address    (rsp_address),
      .rsp_status     (rsp_status),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   ffra_ram #(
      .WIDTH ($bits(seg_type)),
      .DEPTH (FREE_SEGMENTS)
   ) u_seg_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

FILE: rtl/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffra_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_address,
   input logic [1:0]  rsp_status
);
   import ffra_pkg::*;

   // An accepted transaction answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither answered nor busy");

   // Only a successful allocate carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_address == 32'd0))
      else $error("failed transaction returned an address");

   // A result follows an accept or work in progress
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without a transaction");

   // The table loads right after reset
   a_reset_load: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy loading the pool after reset");

endmodule

bind first_fit_range_allocator_top ffra_checker u_ffra_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_address (rsp_address),
   .rsp_status  (rsp_status)
);

FILE: tb/first_fit_range_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top_tb
// Self-checking bench for the first-fit range allocator. A behavioral copy of
// the free-segment table predicts every response; directed tests cover extent
// limits, exact fits, merging, duplicates, table overflow, address wrap and
// length saturation. Random traffic follows under several sender idle rates.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_top_tb;
   import ffra_pkg::*;

   localparam int TABLE_DEPTH = FREE_SEGMENTS_DEF;
   localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH + 40;

   typedef struct {
      logic [31:0] address;
      logic [1:0]  status;
   } grant_type;

   typedef struct {
      logic [31:0] base;
      logic [31:0] extent;
   } lease_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = KIND_ALLOC;
   logic [31:0] req_extent = '0;
   logic [31:0] req_range_base = '0;
   logic        rsp_valid;
   logic [31:0] rsp_address;
   logic [1:0]  rsp_status;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_POOL_START;
   logic [31:0] csr_wdata = '0;

   // Shadow copy of the allocator state
   seg_type     free_tbl[TABLE_DEPTH];
   int          free_count;
   logic [31:0] pool_base;
   logic [30:0] pool_len;

   grant_type   grants_due[$];
   lease_type   leases[$];
   int          mismatches = 0;
   int          idle_pct = 0;

   first_fit_range_allocator_top dut (.*);

   always #5 clock = ~clock;

   // Reload the shadow table as one segment covering the pool
   function automatic void reload_pool();
      free_count = 0;
      if (pool_len != 0) begin
         free_tbl[0].start  = pool_base;
         free_tbl[0].length = pool_len;
         free_count = 1;
      end
      leases.delete();
   endfunction

   function automatic logic [30:0] saturate_len(input longint unsigned v);
      return (v > longint'(LENGTH_MAX)) ? LENGTH_MAX : v[30:0];
   endfunction

   function automatic void drop_segment(input int pos);
      for (int i = pos; i + 1 < free_count; i++) free_tbl[i] = free_tbl[i + 1];
      free_count--;
   endfunction

   // Compute the response of one transaction and update the shadow table
   function automatic grant_type predict_grant(input logic kind, input logic [31:0] ext,
                                               input logic [31:0] base);
      grant_type       g;
      longint unsigned sz;
      int              nx;
      logic [31:0]     fin;
      logic [31:0]     prev_end;
      bit              lo, hi, found;
      g.address = '0;
      g.status  = ST_OK;
      if (ext == 0 || {1'b0, ext} > {2'b00, pool_len}) begin
         g.status = ST_RANGE;
         return g;
      end
      sz = ((longint'({32'b0, ext}) + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
      if (kind == KIND_ALLOC) begin
         found = 0;
         for (int i = 0; i < free_count && !found; i++) begin
            if (longint'({33'b0, free_tbl[i].length}) >= sz) begin
               found = 1;
               g.address = free_tbl[i].start;
               if (longint'({33'b0, free_tbl[i].length}) == sz) drop_segment(i);
               else begin
                  free_tbl[i].start  = free_tbl[i].start + sz[31:0];
                  free_tbl[i].length = free_tbl[i].length - sz[30:0];
               end
            end
         end
         if (!found) g.status = ST_EXHAUSTED;
         return g;
      end
      // release: find the insert point, then merge or insert
      nx = 0;
      while (nx < free_count && free_tbl[nx].start < base) nx++;
      fin = base + sz[31:0];
      lo = 0;
      if (nx > 0) begin
         prev_end = free_tbl[nx - 1].start + {1'b0, free_tbl[nx - 1].length};
         lo = (prev_end == base);
      end
      hi = (nx < free_count) && (free_tbl[nx].start == fin);
      if (lo && hi) begin
         free_tbl[nx - 1].length = saturate_len(longint'({33'b0, free_tbl[nx - 1].length})
                                   + sz + longint'({33'b0, free_tbl[nx].length}));
         drop_segment(nx);
      end else if (lo) begin
         free_tbl[nx - 1].length =
            saturate_len(longint'({33'b0, free_tbl[nx - 1].length}) + sz);
      end else if (hi) begin
         free_tbl[nx].start  = base;
         free_tbl[nx].length = saturate_len(longint'({33'b0, free_tbl[nx].length}) + sz);
      end else if (nx < free_count && free_tbl[nx].start == base) begin
         g.status = ST_OK;
      end else if (free_count >= TABLE_DEPTH) begin
         g.status = ST_FULL;
      end else begin
         for (int i = free_count; i > nx; i--) free_tbl[i] = free_tbl[i - 1];
         free_tbl[nx].start  = base;
         free_tbl[nx].length = saturate_len(sz);
         free_count++;
      end
      return g;
   endfunction

   // Send one transaction; hold start high unless an idle gap follows
   task automatic send_req(input logic kind, input logic [31:0] ext,
                           input logic [31:0] base, output grant_type g);
      start          <= 1'b1;
      req_kind       <= kind;
      req_extent     <= ext;
      req_range_base <= base;
      @(posedge clock);
      while (busy) @(posedge clock);
      g = predict_grant(kind, ext, base);
      grants_due.push_back(g);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (grants_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register while idle and reload the shadow pool
   task automatic csr_write(input logic idx, input logic [31:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_POOL_START) pool_base = value;
      else pool_len = value[30:0];
      reload_pool();
      @(posedge clock);
   endtask

   // Compare each response with the oldest prediction
   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_valid) begin
         if (grants_due.size() == 0) begin
            $error("unexpected response: address %h status %0d", rsp_address, rsp_status);
            mismatches++;
         end else begin
            g = grants_due.pop_front();
            if (rsp_address !== g.address) begin
               $error("address: expected %h, actual %h", g.address, rsp_address);
               mismatches++;
            end
            if (rsp_status !== g.status) begin
               $error("status: expected %0d, actual %0d", g.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   task automatic test_extent_limits();
      grant_type g;
      send_req(KIND_ALLOC, 32'd0, 32'd0, g);
      send_req(KIND_RELEASE, 32'd0, 32'h8000_0000, g);
      send_req(KIND_ALLOC, 32'h4000_0001, 32'd0, g);
      send_req(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, g);
      send_req(KIND_ALLOC, 32'd1, 32'd0, g);
      send_req(KIND_ALLOC, 32'd33, 32'd0, g);
      send_req(KIND_RELEASE, 32'd1, 32'h8000_0000, g);
      send_req(KIND_ALLOC, 32'h4000_0000, 32'd0, g);
      drain();
   endtask

   task automatic test_fit_merge_duplicate();
      grant_type g;
      csr_write(CSR_POOL_START, 32'h0000_1000);
      csr_write(CSR_POOL_LENGTH, 32'h0000_0100);
      send_req(KIND_ALLOC, 32'h100, 32'd0, g);
      send_req(KIND_ALLOC, 32'd1, 32'd0, g);
      send_req(KIND_RELEASE, 32'h100, 32'h1000, g);
      repeat (3) send_req(KIND_ALLOC, 32'd64, 32'd0, g);
      send_req(KIND_RELEASE, 32'd64, 32'h1040, g);
      send_req(KIND_RELEASE, 32'd64, 32'h1000, g);
      send_req(KIND_RELEASE, 32'd64, 32'h1080, g);
      send_req(KIND_RELEASE, 32'd32, 32'h1000, g);
      send_req(KIND_RELEASE, 32'h101, 32'h2000, g);
      // masked to zero length: the table is empty
      csr_write(CSR_POOL_LENGTH, 32'h8000_0000);
      send_req(KIND_ALLOC, 32'd1, 32'd0, g);
      csr_write(CSR_POOL_LENGTH, 32'd32);
      send_req(KIND_ALLOC, 32'd33, 32'd0, g);
      send_req(KIND_ALLOC, 32'd32, 32'd0, g);
      send_req(KIND_ALLOC, 32'd1, 32'd0, g);
      drain();
   endtask

   task automatic test_table_full();
      grant_type g;
      csr_write(CSR_POOL_START, 32'h0000_0000);
      csr_write(CSR_POOL_LENGTH, 32'd4096);
      for (int i = 0; i < 128; i++) send_req(KIND_ALLOC, 32'd32, 32'd0, g);
      for (int i = 0; i < 128; i += 2) send_req(KIND_RELEASE, 32'd32, i * 32, g);
      send_req(KIND_RELEASE, 32'd32, 32'd8192, g);
      send_req(KIND_RELEASE, 32'd32, 32'd32, g);
      send_req(KIND_RELEASE, 32'd32, 32'd8192, g);
      drain();
   endtask

   task automatic test_wrap_and_cap();
      grant_type g;
      csr_write(CSR_POOL_START, 32'hFFFF_FFFF);
      csr_write(CSR_POOL_LENGTH, 32'd64);
      send_req(KIND_ALLOC, 32'd32, 32'd0, g);
      send_req(KIND_ALLOC, 32'd32, 32'd0, g);
      send_req(KIND_RELEASE, 32'd32, 32'hFFFF_FFFF, g);
      csr_write(CSR_POOL_START, 32'h0000_0000);
      csr_write(CSR_POOL_LENGTH, 32'h7FFF_FFFF);
      send_req(KIND_ALLOC, 32'h4000_0000, 32'd0, g);
      send_req(KIND_RELEASE, 32'h4000_0000, 32'd0, g);
      send_req(KIND_RELEASE, 32'h1000, 32'h7FFF_FFFF, g);
      send_req(KIND_RELEASE, 32'h7FFF_FFFF, 32'h8000_1000, g);
      drain();
   endtask

   // Random traffic: mostly allocations and releases of granted ranges
   task automatic test_random(input int pct, input int count);
      grant_type   g;
      lease_type   l;
      int          r, pick;
      logic [31:0] ext;
      idle_pct = pct;
      csr_write(CSR_POOL_START, $urandom);
      if ($urandom_range(3) == 0) csr_write(CSR_POOL_LENGTH, $urandom);
      else csr_write(CSR_POOL_LENGTH, $urandom_range(32, 65536));
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 50) begin
            ext = ($urandom_range(19) == 0) ? $urandom : $urandom_range(1, 2048);
            send_req(KIND_ALLOC, ext, $urandom, g);
            if (g.status == ST_OK) begin
               l.base = g.address;
               l.extent = ext;
               leases.push_back(l);
            end
         end else if (r < 88 && leases.size() != 0) begin
            pick = $urandom_range(leases.size() - 1);
            l = leases[pick];
            leases.delete(pick);
            send_req(KIND_RELEASE, l.extent, l.base, g);
         end else begin
            ext = ($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 4096);
            send_req(KIND_RELEASE, ext, $urandom, g);
         end
      end
      drain();
   endtask

   initial begin
      free_count = 0;
      pool_base = POOL_START_RST;
      pool_len  = POOL_LENGTH_RST;
      reload_pool();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extent_limits();
      test_fit_merge_duplicate();
      test_table_full();
      test_wrap_and_cap();
      test_random(0, 340);
      test_random(64, 340);
      test_random(30, 340);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // Hard stop for a hung handshake
   initial begin
      #60_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
